FILE: hw/rtl/spinor_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer package
// Shared codes, command bytes, item types and result builders for the
// sequencer, its result queue and the top level.
// ----------------------------------------------------------------------------
package spinor_pkg;

    // Largest page that program or read may move in one operation.
    localparam int PAGE_BYTES = 256;

    // Depth of the result queue; one step pushes at most two results.
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);
    localparam int MAX_PUSH   = 2;

    localparam logic [23:0] PART_ID_RESET = 24'h014014;

    // Input actions.
    localparam logic [1:0] ACT_REQUEST   = 2'd0;
    localparam logic [1:0] ACT_PROG_DATA = 2'd1;
    localparam logic [1:0] ACT_RX_BYTE   = 2'd2;

    // Operation codes.
    localparam logic [3:0] OP_READ_ID     = 4'd0;
    localparam logic [3:0] OP_WRITE_EN    = 4'd1;
    localparam logic [3:0] OP_WRITE_DIS   = 4'd2;
    localparam logic [3:0] OP_READ_STATUS = 4'd3;
    localparam logic [3:0] OP_WAIT_READY  = 4'd4;
    localparam logic [3:0] OP_SECTOR_ERS  = 4'd5;
    localparam logic [3:0] OP_BLOCK_ERS   = 4'd6;
    localparam logic [3:0] OP_PAGE_PROG   = 4'd7;
    localparam logic [3:0] OP_PAGE_READ   = 4'd8;

    // Result kinds.
    localparam logic [1:0] KIND_SPI  = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Flash command bytes.
    localparam logic [7:0] CMD_RDID  = 8'h9f;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_WRDI  = 8'h04;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_BE    = 8'hd8;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_DUMMY = 8'h00;

    // Write-in-progress flag in the status register.
    localparam int SR_BUSY_BIT = 0;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  operation;
        logic [23:0] address;
        logic [8:0]  length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  mosi_byte;
        logic        release_select;
        logic [7:0]  host_byte;
        logic [23:0] identifier;
        logic        part_known;
        logic        outcome;
        logic        last;
    } out_item_t;

    // Results produced by one step, in order.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_res_t;

    function automatic out_item_t send_item(input logic [7:0] b, input logic rel);
        out_item_t r;
        r                = '0;
        r.kind           = KIND_SPI;
        r.mosi_byte      = b;
        r.release_select = rel;
        return r;
    endfunction

    function automatic out_item_t done_item(input logic [7:0] host,
                                            input logic [23:0] id,
                                            input logic known,
                                            input logic fail);
        out_item_t r;
        r            = '0;
        r.kind       = KIND_DONE;
        r.host_byte  = host;
        r.identifier = id;
        r.part_known = known;
        r.outcome    = fail;
        return r;
    endfunction

    function automatic out_item_t host_item(input logic [7:0] host);
        out_item_t r;
        r           = '0;
        r.kind      = KIND_HOST;
        r.host_byte = host;
        return r;
    endfunction

endpackage

FILE: hw/rtl/spinor_seq.sv
// ----------------------------------------------------------------------------
// SPI NOR command sequencer state machine
// Decides, per accepted item, the next phase and the zero to two results.
// ----------------------------------------------------------------------------
module spinor_seq
    import spinor_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  in_item_t    item,
    input  logic [23:0] expected_id,
    output step_res_t   res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ID_CMD, PH_ID_B1, PH_ID_B2, PH_ID_B3, PH_SINGLE,
        PH_POLL_CMD, PH_POLL_DATA, PH_PRE_WREN, PH_OPCODE, PH_ADDR_HI,
        PH_ADDR_MID, PH_ADDR_LO, PH_PROG_NEED, PH_PROG_SENT, PH_READ_DATA,
        PH_FINAL_WRDIS
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [3:0]  op_reg,     op_next;
    logic [23:0] addr_reg,   addr_next;
    logic [8:0]  cnt_reg,    cnt_next;
    logic [23:0] id_reg,     id_next;

    logic [8:0]  cnt_dec;
    logic [23:0] id_shift;
    logic        erase;
    logic        len_bad;
    out_item_t   r0, r1;
    logic [1:0]  n;

    assign cnt_dec  = cnt_reg - 9'd1;
    assign id_shift = {id_reg[15:0], item.data_byte};
    assign erase    = (op_reg == OP_SECTOR_ERS) || (op_reg == OP_BLOCK_ERS);
    assign len_bad  = (item.length == 9'd0) || (32'(item.length) > 32'(PAGE_BYTES));

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        r0         = '0;
        r1         = '0;
        n          = 2'd0;

        unique case (item.action)
            ACT_REQUEST: begin
                if (phase_reg == PH_IDLE) begin
                    op_next   = item.operation;
                    addr_next = item.address;
                    cnt_next  = item.length;
                    n         = 2'd1;
                    priority if (item.operation == OP_READ_ID) begin
                        id_next    = '0;
                        phase_next = PH_ID_CMD;
                        r0         = send_item(CMD_RDID, 1'b0);
                    end else if (item.operation == OP_WRITE_EN ||
                                 item.operation == OP_WRITE_DIS) begin
                        phase_next = PH_SINGLE;
                        r0 = send_item((item.operation == OP_WRITE_EN) ? CMD_WREN : CMD_WRDI,
                                       1'b1);
                    end else if (item.operation == OP_READ_STATUS ||
                                 item.operation == OP_WAIT_READY) begin
                        phase_next = PH_POLL_CMD;
                        r0         = send_item(CMD_RDSR, 1'b0);
                    end else if ((item.operation == OP_PAGE_PROG ||
                                  item.operation == OP_PAGE_READ) && len_bad) begin
                        phase_next = PH_IDLE;
                        r0         = done_item(8'd0, 24'd0, 1'b0, 1'b1);
                    end else if (item.operation == OP_PAGE_READ) begin
                        phase_next = PH_OPCODE;
                        r0         = send_item(CMD_READ, 1'b0);
                    end else if (item.operation == OP_SECTOR_ERS ||
                                 item.operation == OP_BLOCK_ERS ||
                                 item.operation == OP_PAGE_PROG) begin
                        phase_next = PH_PRE_WREN;
                        r0         = send_item(CMD_WREN, 1'b1);
                    end else begin
                        phase_next = PH_IDLE;
                        r0         = done_item(8'd0, 24'd0, 1'b0, 1'b1);
                    end
                end
            end
            ACT_PROG_DATA: begin
                if (phase_reg == PH_PROG_NEED) begin
                    cnt_next   = cnt_dec;
                    phase_next = PH_PROG_SENT;
                    r0         = send_item(item.data_byte, cnt_dec == 9'd0);
                    n          = 2'd1;
                end
            end
            ACT_RX_BYTE: begin
                unique case (phase_reg)
                    PH_ID_CMD: begin
                        phase_next = PH_ID_B1;
                        r0 = send_item(CMD_DUMMY, 1'b0);
                        n  = 2'd1;
                    end
                    PH_ID_B1: begin
                        id_next    = id_shift;
                        phase_next = PH_ID_B2;
                        r0 = send_item(CMD_DUMMY, 1'b0);
                        n  = 2'd1;
                    end
                    PH_ID_B2: begin
                        id_next    = id_shift;
                        phase_next = PH_ID_B3;
                        r0 = send_item(CMD_DUMMY, 1'b1);
                        n  = 2'd1;
                    end
                    PH_ID_B3: begin
                        id_next    = id_shift;
                        phase_next = PH_IDLE;
                        r0 = done_item(8'd0, id_shift, id_shift == expected_id, 1'b0);
                        n  = 2'd1;
                    end
                    PH_SINGLE, PH_FINAL_WRDIS: begin
                        phase_next = PH_IDLE;
                        r0 = done_item(8'd0, 24'd0, 1'b0, 1'b0);
                        n  = 2'd1;
                    end
                    PH_POLL_CMD: begin
                        phase_next = PH_POLL_DATA;
                        r0 = send_item(CMD_DUMMY, 1'b1);
                        n  = 2'd1;
                    end
                    PH_POLL_DATA: begin
                        n = 2'd1;
                        priority if (op_reg == OP_READ_STATUS) begin
                            phase_next = PH_IDLE;
                            r0 = done_item(item.data_byte, 24'd0, 1'b0, 1'b0);
                        end else if (item.data_byte[SR_BUSY_BIT]) begin
                            phase_next = PH_POLL_CMD;
                            r0 = send_item(CMD_RDSR, 1'b0);
                        end else if (op_reg == OP_WAIT_READY) begin
                            phase_next = PH_IDLE;
                            r0 = done_item(item.data_byte, 24'd0, 1'b0, 1'b0);
                        end else begin
                            phase_next = PH_FINAL_WRDIS;
                            r0 = send_item(CMD_WRDI, 1'b1);
                        end
                    end
                    PH_PRE_WREN: begin
                        phase_next = PH_OPCODE;
                        n = 2'd1;
                        unique case (op_reg)
                            OP_SECTOR_ERS: r0 = send_item(CMD_SE, 1'b0);
                            OP_BLOCK_ERS:  r0 = send_item(CMD_BE, 1'b0);
                            OP_PAGE_PROG:  r0 = send_item(CMD_PP, 1'b0);
                            default:       r0 = send_item(CMD_READ, 1'b0);
                        endcase
                    end
                    PH_OPCODE: begin
                        phase_next = PH_ADDR_HI;
                        r0 = send_item(addr_reg[23:16], 1'b0);
                        n  = 2'd1;
                    end
                    PH_ADDR_HI: begin
                        phase_next = PH_ADDR_MID;
                        r0 = send_item(addr_reg[15:8], 1'b0);
                        n  = 2'd1;
                    end
                    PH_ADDR_MID: begin
                        phase_next = PH_ADDR_LO;
                        r0 = send_item(addr_reg[7:0], erase);
                        n  = 2'd1;
                    end
                    PH_ADDR_LO: begin
                        priority if (erase) begin
                            phase_next = PH_POLL_CMD;
                            r0 = send_item(CMD_RDSR, 1'b0);
                            n  = 2'd1;
                        end else if (op_reg == OP_PAGE_PROG) begin
                            phase_next = PH_PROG_NEED;
                        end else begin
                            phase_next = PH_READ_DATA;
                            r0 = send_item(CMD_DUMMY, cnt_reg == 9'd1);
                            n  = 2'd1;
                        end
                    end
                    PH_PROG_SENT: begin
                        if (cnt_reg == 9'd0) begin
                            phase_next = PH_POLL_CMD;
                            r0 = send_item(CMD_RDSR, 1'b0);
                            n  = 2'd1;
                        end else begin
                            phase_next = PH_PROG_NEED;
                        end
                    end
                    PH_READ_DATA: begin
                        cnt_next = cnt_dec;
                        r0 = host_item(item.data_byte);
                        n  = 2'd2;
                        if (cnt_dec == 9'd0) begin
                            phase_next = PH_IDLE;
                            r1 = done_item(8'd0, 24'd0, 1'b0, 1'b0);
                        end else begin
                            r1 = send_item(CMD_DUMMY, cnt_dec == 9'd1);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (n == 2'd1) begin
            r0.last = 1'b1;
        end
        if (n == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    assign res.count  = n;
    assign res.first  = r0;
    assign res.second = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            op_reg    <= '0;
            addr_reg  <= '0;
            cnt_reg   <= '0;
            id_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
        end
    end

endmodule

FILE: hw/rtl/spinor_res_fifo.sv
// ----------------------------------------------------------------------------
// SPI NOR sequencer result queue
// Small queue: up to two results in per cycle, one out while m_ready is high.
// ----------------------------------------------------------------------------
module spinor_res_fifo
    import spinor_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  step_res_t push_res,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    out_item_t            mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] cnt_reg,    cnt_next;
    logic [1:0]           push_cnt;
    logic                 pop;

    assign push_cnt = push ? push_res.count : 2'd0;
    assign pop      = (cnt_reg != '0) && m_ready;
    assign cnt_next = cnt_reg + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);

    // Space for the worst-case step is judged on the registered fill level.
    assign room    = 32'(cnt_reg) <= (RES_DEPTH - MAX_PUSH);
    assign m_valid = cnt_reg != '0;
    assign m_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_res.first;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= push_res.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/spi_nor_flash_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core
// Host-side command engine for 24-bit addressed SPI NOR flash: turns
// operation requests, program data and received bytes into MOSI bytes,
// read data and completion reports.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake            Payload
//   s_        in   s_valid / s_ready    s_item   (in_item_t)
//   m_        out  m_valid / m_ready    m_item   (out_item_t)
//   cfg_      in   cfg_valid/cfg_ready  cfg_data (expected part id, 24 bits)
//
// The sequencer decides the results of an item in a single pass and writes
// them straight into a four-entry result queue, so a new item can be
// accepted on every clock while the queue has room for two more results.
// Results leave at one per cycle while m_ready is high; only a page read
// byte produces two, which is what bounds the sustained rate during reads.
// Reset (aresetn low at a clock edge) returns the sequencer to idle, empties
// the queue and loads the expected part identifier with its default.
// A stalled m_ready only holds off new items once the queue is nearly full.
//
module spi_nor_flash_command_sequencer_core
    import spinor_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);

    logic        accept;
    logic        room;
    logic [23:0] part_id_reg;
    step_res_t   step_res;

    // The register may be written at any time and a write is registered; it
    // is only looked at when the last identifier byte of a read ID arrives.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_id_reg <= PART_ID_RESET;
        end else if (cfg_valid) begin
            part_id_reg <= cfg_data;
        end
    end

    // Readiness depends only on the queue's registered fill level, so there
    // is no combinational path from m_ready through to s_ready.
    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    // The sequencer state machine: phase, operation, address, byte count and
    // the identifier being assembled. Its results for the accepted item are
    // combinational and are captured by the queue at the same edge.
    spinor_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (s_item),
        .expected_id (part_id_reg),
        .res         (step_res)
    );

    // The result queue decouples the two sides; its entries are the output
    // register of the block.
    spinor_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_res (step_res),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

FILE: tb/spi_nor_flash_command_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core testbench
// Plays the host and the flash on the item channel, predicts every command
// frame, read byte and completion, and checks each result item in order.
// ----------------------------------------------------------------------------

import spinor_pkg::*;

// Predicted position of the sequencer within an operation.
typedef enum logic [4:0] {
    PH_IDLE, PH_ID_CMD, PH_ID_B1, PH_ID_B2, PH_ID_B3, PH_SINGLE,
    PH_POLL_CMD, PH_POLL_DATA, PH_PRE_WREN, PH_OPCODE, PH_ADDR_HI,
    PH_ADDR_MID, PH_ADDR_LO, PH_PROG_NEED, PH_PROG_SENT, PH_READ_DATA,
    PH_FINAL_WRDIS
} seq_phase_t;

class spi_frame_predictor;
    logic [23:0] part_id;
    seq_phase_t  phase;
    logic [3:0]  cur_op;
    logic [23:0] cur_addr;
    logic [8:0]  bytes_left;
    logic [23:0] id_acc;
    out_item_t   due[$];
    int          n_errors;
    int          n_checked;

    function new();
        part_id    = PART_ID_RESET;
        phase      = PH_IDLE;
        cur_op     = '0;
        cur_addr   = '0;
        bytes_left = '0;
        id_acc     = '0;
        n_errors   = 0;
        n_checked  = 0;
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] mosi, logic rel,
                             logic [7:0] host, logic [23:0] id, logic known,
                             logic fail);
        out_item_t r;
        r.kind           = kind;
        r.mosi_byte      = mosi;
        r.release_select = rel;
        r.host_byte      = host;
        r.identifier     = id;
        r.part_known     = known;
        r.outcome        = fail;
        r.last           = 1'b0;
        due.push_back(r);
    endfunction

    function void spi(logic [7:0] b, logic rel);
        add_result(KIND_SPI, b, rel, 8'h00, 24'h000000, 1'b0, 1'b0);
    endfunction

    function void finish_op(logic [7:0] host, logic [23:0] id, logic known, logic fail);
        add_result(KIND_DONE, 8'h00, 1'b0, host, id, known, fail);
        phase = PH_IDLE;
    endfunction

    // Advances the predicted sequencer by one accepted item and queues the
    // results it causes. Returns 0 when the block ignores the item.
    function bit take_item(in_item_t it);
        int        n0;
        bit        erase;
        bit        taken;
        out_item_t tail;
        n0    = due.size();
        erase = (cur_op == OP_SECTOR_ERS) || (cur_op == OP_BLOCK_ERS);
        taken = 1'b1;
        case (it.action)
            ACT_REQUEST: begin
                if (phase != PH_IDLE) begin
                    taken = 1'b0;
                end else begin
                    cur_op     = it.operation;
                    cur_addr   = it.address;
                    bytes_left = it.length;
                    case (it.operation)
                        OP_READ_ID: begin
                            id_acc = '0;
                            phase  = PH_ID_CMD;
                            spi(CMD_RDID, 1'b0);
                        end
                        OP_WRITE_EN, OP_WRITE_DIS: begin
                            phase = PH_SINGLE;
                            spi(it.operation == OP_WRITE_EN ? CMD_WREN : CMD_WRDI, 1'b1);
                        end
                        OP_READ_STATUS, OP_WAIT_READY: begin
                            phase = PH_POLL_CMD;
                            spi(CMD_RDSR, 1'b0);
                        end
                        OP_SECTOR_ERS, OP_BLOCK_ERS: begin
                            phase = PH_PRE_WREN;
                            spi(CMD_WREN, 1'b1);
                        end
                        OP_PAGE_PROG, OP_PAGE_READ: begin
                            if (it.length == 9'd0 || int'(it.length) > PAGE_BYTES) begin
                                finish_op(8'h00, 24'h000000, 1'b0, 1'b1);
                            end else if (it.operation == OP_PAGE_READ) begin
                                phase = PH_OPCODE;
                                spi(CMD_READ, 1'b0);
                            end else begin
                                phase = PH_PRE_WREN;
                                spi(CMD_WREN, 1'b1);
                            end
                        end
                        default: finish_op(8'h00, 24'h000000, 1'b0, 1'b1);
                    endcase
                end
            end
            ACT_PROG_DATA: begin
                if (phase == PH_PROG_NEED) begin
                    bytes_left = bytes_left - 9'd1;
                    phase      = PH_PROG_SENT;
                    spi(it.data_byte, bytes_left == 9'd0);
                end else begin
                    taken = 1'b0;
                end
            end
            ACT_RX_BYTE: begin
                case (phase)
                    PH_ID_CMD: begin
                        phase = PH_ID_B1;
                        spi(CMD_DUMMY, 1'b0);
                    end
                    PH_ID_B1: begin
                        id_acc = {id_acc[15:0], it.data_byte};
                        phase  = PH_ID_B2;
                        spi(CMD_DUMMY, 1'b0);
                    end
                    PH_ID_B2: begin
                        id_acc = {id_acc[15:0], it.data_byte};
                        phase  = PH_ID_B3;
                        spi(CMD_DUMMY, 1'b1);
                    end
                    PH_ID_B3: begin
                        id_acc = {id_acc[15:0], it.data_byte};
                        finish_op(8'h00, id_acc, id_acc == part_id, 1'b0);
                    end
                    PH_SINGLE, PH_FINAL_WRDIS: finish_op(8'h00, 24'h000000, 1'b0, 1'b0);
                    PH_POLL_CMD: begin
                        phase = PH_POLL_DATA;
                        spi(CMD_DUMMY, 1'b1);
                    end
                    PH_POLL_DATA: begin
                        if (cur_op == OP_READ_STATUS) begin
                            finish_op(it.data_byte, 24'h000000, 1'b0, 1'b0);
                        end else if (it.data_byte[SR_BUSY_BIT]) begin
                            phase = PH_POLL_CMD;
                            spi(CMD_RDSR, 1'b0);
                        end else if (cur_op == OP_WAIT_READY) begin
                            finish_op(it.data_byte, 24'h000000, 1'b0, 1'b0);
                        end else begin
                            phase = PH_FINAL_WRDIS;
                            spi(CMD_WRDI, 1'b1);
                        end
                    end
                    PH_PRE_WREN: begin
                        phase = PH_OPCODE;
                        spi(cur_op == OP_SECTOR_ERS ? CMD_SE :
                            cur_op == OP_BLOCK_ERS  ? CMD_BE :
                            cur_op == OP_PAGE_PROG  ? CMD_PP : CMD_READ, 1'b0);
                    end
                    PH_OPCODE: begin
                        phase = PH_ADDR_HI;
                        spi(cur_addr[23:16], 1'b0);
                    end
                    PH_ADDR_HI: begin
                        phase = PH_ADDR_MID;
                        spi(cur_addr[15:8], 1'b0);
                    end
                    PH_ADDR_MID: begin
                        phase = PH_ADDR_LO;
                        spi(cur_addr[7:0], erase);
                    end
                    PH_ADDR_LO: begin
                        if (erase) begin
                            phase = PH_POLL_CMD;
                            spi(CMD_RDSR, 1'b0);
                        end else if (cur_op == OP_PAGE_PROG) begin
                            phase = PH_PROG_NEED;
                        end else begin
                            phase = PH_READ_DATA;
                            spi(CMD_DUMMY, bytes_left == 9'd1);
                        end
                    end
                    PH_PROG_SENT: begin
                        if (bytes_left == 9'd0) begin
                            phase = PH_POLL_CMD;
                            spi(CMD_RDSR, 1'b0);
                        end else begin
                            phase = PH_PROG_NEED;
                        end
                    end
                    PH_READ_DATA: begin
                        add_result(KIND_HOST, 8'h00, 1'b0, it.data_byte, 24'h000000,
                                   1'b0, 1'b0);
                        bytes_left = bytes_left - 9'd1;
                        if (bytes_left == 9'd0) begin
                            finish_op(8'h00, 24'h000000, 1'b0, 1'b0);
                        end else begin
                            spi(CMD_DUMMY, bytes_left == 9'd1);
                        end
                    end
                    default: taken = 1'b0;
                endcase
            end
            default: taken = 1'b0;
        endcase
        if (due.size() > n0) begin
            tail      = due.pop_back();
            tail.last = 1'b1;
            due.push_back(tail);
        end
        return taken;
    endfunction

    task report_mismatch(string what);
        n_errors++;
        $display("MISMATCH: %s", what);
    endtask

    task compare_field(string name, logic [23:0] got, logic [23:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      n_checked, name, got, want));
        end
    endtask

    task check_result(out_item_t got);
        out_item_t want;
        n_checked++;
        if (due.size() == 0) begin
            report_mismatch($sformatf("result %0d (kind %0d) arrived with nothing expected",
                                      n_checked, got.kind));
            return;
        end
        want = due.pop_front();
        compare_field("kind", 24'(got.kind), 24'(want.kind));
        compare_field("mosi_byte", 24'(got.mosi_byte), 24'(want.mosi_byte));
        compare_field("release_select", 24'(got.release_select), 24'(want.release_select));
        compare_field("host_byte", 24'(got.host_byte), 24'(want.host_byte));
        compare_field("identifier", got.identifier, want.identifier);
        compare_field("part_known", 24'(got.part_known), 24'(want.part_known));
        compare_field("outcome", 24'(got.outcome), 24'(want.outcome));
        compare_field("last", 24'(got.last), 24'(want.last));
    endtask
endclass

module spi_nor_flash_command_sequencer_core_tb;

    // The block ignores the fourth action code; it has no name in the package.
    localparam logic [1:0] ACT_UNUSED        = 2'd3;
    // Operation codes the block does not support.
    localparam logic [3:0] OP_UNSUPPORTED_LO = 4'd9;
    localparam logic [3:0] OP_UNSUPPORTED_HI = 4'd15;

    localparam int PHASE_ITEMS  = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int SETTLE_LIMIT = 5000;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_data;

    spi_frame_predictor frames;

    int n_effective = 0;
    int n_settings  = 0;
    bit sender_idles;
    bit receiver_idles;
    bit id_echo;
    int hold_left   = 0;

    spi_nor_flash_command_sequencer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The result side. A long hold-off requested by the stimulus is counted
    // down here, one cycle per falling edge; otherwise ready drops in short
    // random bursts whenever idling is enabled.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every result item taken by the receiver is checked against the oldest
    // prediction still outstanding.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames.check_result(m_item);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Offers one item, waits for its handshake and feeds it to the predictor.
    // Called and returning at a falling edge; valid stays high afterwards so
    // that a following item goes out back to back unless a gap is drawn.
    task automatic push_item(in_item_t it);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (frames.take_item(it)) begin
            n_effective++;
        end
        @(negedge aclk);
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // Drops valid and waits until every predicted result has been seen, then
    // waits out a settling tail so that nothing is still in flight inside the block.
    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (frames.due.size() != 0 && waited < SETTLE_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (frames.due.size() != 0) begin
            frames.report_mismatch($sformatf("%0d expected results never arrived",
                                             frames.due.size()));
            frames.due.delete();
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic load_part_id(logic [23:0] id);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        frames.part_id = id;
        n_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t stray_item(logic [1:0] act);
        in_item_t it;
        it.action    = act;
        it.operation = 4'($urandom_range(0, 15));
        it.address   = 24'($urandom_range(0, 24'hffffff));
        it.length    = 9'($urandom_range(0, 511));
        it.data_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Builds the item that the host and the flash would send next, given
    // where the predicted sequencer stands. Noise replaces about one item in
    // ten with an arbitrary one. While closing, the flash reports itself
    // ready so that any status poll ends.
    function automatic in_item_t flow_item(bit noisy, bit closing);
        in_item_t it;
        int       pick;
        bit       echo;
        it        = stray_item(ACT_RX_BYTE);
        it.length = 9'($urandom_range(1, 6));
        echo      = id_echo || $urandom_range(0, 3) != 0;
        if (noisy && $urandom_range(0, 9) == 0) begin
            it.action = 2'($urandom_range(0, 3));
            it.length = 9'($urandom_range(0, 511));
            return it;
        end
        case (frames.phase)
            PH_IDLE: begin
                it.action = ACT_REQUEST;
                if ($urandom_range(0, 11) != 0) begin
                    it.operation = 4'($urandom_range(0, OP_PAGE_READ));
                end
                // Mostly short transfers, with bad lengths and the odd longer one.
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    it.length = '0;
                end else if (pick == 1) begin
                    it.length = 9'($urandom_range(PAGE_BYTES + 1, 511));
                end else if (pick == 2) begin
                    it.length = 9'($urandom_range(7, 40));
                end
            end
            PH_PROG_NEED: it.action = ACT_PROG_DATA;
            PH_ID_B1: if (echo) it.data_byte = frames.part_id[23:16];
            PH_ID_B2: if (echo) it.data_byte = frames.part_id[15:8];
            PH_ID_B3: if (echo) it.data_byte = frames.part_id[7:0];
            PH_POLL_DATA: it.data_byte[SR_BUSY_BIT] = !closing && $urandom_range(0, 2) == 0;
            default: ;
        endcase
        return it;
    endfunction

    // Issues one request and plays the flash until the operation is over.
    // With meddle set, a second request, a program data byte and an item of
    // the unused action are pushed while the block is busy; all three must
    // be ignored.
    task automatic run_op(logic [3:0] op, logic [23:0] addr, logic [8:0] len, bit meddle);
        in_item_t it;
        it           = stray_item(ACT_REQUEST);
        it.operation = op;
        it.address   = addr;
        it.length    = len;
        push_item(it);
        if (meddle) begin
            push_item(stray_item(ACT_REQUEST));
            push_item(stray_item(ACT_PROG_DATA));
            push_item(stray_item(ACT_UNUSED));
        end
        while (frames.phase != PH_IDLE) begin
            push_item(flow_item(1'b0, 1'b0));
        end
    endtask

    initial begin
        logic [23:0] part_ids [5];
        int          base;
        int          n_directed;

        frames         = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_item         = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        id_echo        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, under the reset part identifier. Received bytes and
        // program data that nothing waits for are dropped while idle.
        push_item(stray_item(ACT_RX_BYTE));
        push_item(stray_item(ACT_PROG_DATA));
        push_item(stray_item(ACT_UNUSED));
        id_echo = 1'b1;
        run_op(OP_READ_ID, 24'h000000, 9'd1, 1'b0);
        id_echo = 1'b0;
        run_op(OP_READ_ID, 24'hffffff, 9'd1, 1'b0);
        run_op(OP_WRITE_EN, 24'($urandom), 9'd1, 1'b1);
        run_op(OP_WRITE_DIS, 24'($urandom), 9'd1, 1'b0);
        run_op(OP_READ_STATUS, 24'($urandom), 9'd1, 1'b0);
        run_op(OP_WAIT_READY, 24'($urandom), 9'd1, 1'b0);
        run_op(OP_SECTOR_ERS, 24'h000000, 9'd1, 1'b0);
        run_op(OP_BLOCK_ERS, 24'hffffff, 9'd1, 1'b0);
        run_op(OP_PAGE_PROG, 24'h5a0f3c, 9'd1, 1'b0);
        run_op(OP_PAGE_PROG, 24'ha5f0c3, 9'd3, 1'b1);
        run_op(OP_PAGE_READ, 24'hffffff, 9'd1, 1'b0);
        run_op(OP_PAGE_READ, 24'h000000, 9'(PAGE_BYTES), 1'b0);
        // Bad lengths fail straight away, as do the unsupported codes.
        run_op(OP_PAGE_PROG, 24'($urandom), 9'd0, 1'b0);
        run_op(OP_PAGE_READ, 24'($urandom), 9'd0, 1'b0);
        run_op(OP_PAGE_PROG, 24'($urandom), 9'(PAGE_BYTES + 1), 1'b0);
        run_op(OP_PAGE_READ, 24'($urandom), 9'h1ff, 1'b0);
        run_op(OP_UNSUPPORTED_LO, 24'($urandom), 9'd1, 1'b0);
        run_op(OP_UNSUPPORTED_HI, 24'($urandom), 9'd1, 1'b0);
        settle();
        n_directed = n_effective;

        // Random part, one stretch per part identifier setting. The second
        // stretch opens with a long output hold-off so that the result queue
        // fills and the input stalls; the last runs without any idling.
        part_ids = '{24'h000000, 24'hffffff, 24'($urandom), 24'($urandom), PART_ID_RESET};
        for (int p = 0; p < 5; p++) begin
            load_part_id(part_ids[p]);
            sender_idles   = (p != 4);
            receiver_idles = (p != 4);
            if (p == 1) begin
                hold_left = HOLD_CYCLES;
            end
            base = n_effective;
            while (n_effective - base < PHASE_ITEMS || frames.phase != PH_IDLE) begin
                push_item(flow_item(n_effective - base < PHASE_ITEMS,
                                    n_effective - base >= PHASE_ITEMS));
            end
            settle();
        end

        $display("Drove %0d items that the block acted on (%0d directed), checked %0d results.",
                 n_effective, n_directed, frames.n_checked);
        $display("Used %0d part id settings, every operation, bad lengths and a %0d-cycle stall.",
                 n_settings, HOLD_CYCLES);
        if (frames.n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
